FILE: hw/rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and codes of the priority ready queue scheduler.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_PICK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REM_DONE,
    S_PICK_RD,
    S_PICK_DONE
  } prq_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_ADD,
    CMD_FIN_OK,
    CMD_FIN_NOT_FOUND,
    CMD_SRCH_RD,
    CMD_SRCH_NEXT,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_REMOVE_DONE,
    CMD_PICK_RD,
    CMD_PICK_DONE
  } prq_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cur_valid;
    logic       count_zero;
    logic       match;
    logic       srch_last;
    logic       shift_last;
    logic       mask_any;
  } prq_status_t;

endpackage

FILE: hw/rtl/prq_ctrl.sv
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer that steps the datapath through add, remove and pick.
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  prq_pkg::prq_status_t stat,
  output prq_pkg::prq_cmd_t  cmd
);

  prq_pkg::prq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != prq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      prq_pkg::S_IDLE: begin
        if (start) state_next = prq_pkg::S_DECODE;
      end
      prq_pkg::S_DECODE: begin
        case (stat.func)
          prq_pkg::FUNC_ADD: state_next = prq_pkg::S_ADD;
          prq_pkg::FUNC_REMOVE: begin
            if (!stat.cur_valid || stat.count_zero) state_next = prq_pkg::S_IDLE;
            else state_next = prq_pkg::S_SRCH_RD;
          end
          prq_pkg::FUNC_PICK: begin
            if (stat.mask_any) state_next = prq_pkg::S_PICK_RD;
            else state_next = prq_pkg::S_IDLE;
          end
          default: state_next = prq_pkg::S_IDLE;
        endcase
      end
      prq_pkg::S_ADD:     state_next = prq_pkg::S_IDLE;
      prq_pkg::S_SRCH_RD: state_next = prq_pkg::S_SRCH_CMP;
      prq_pkg::S_SRCH_CMP: begin
        if (stat.match) begin
          if (stat.srch_last) state_next = prq_pkg::S_IDLE;
          else state_next = prq_pkg::S_SHIFT_RD;
        end else if (stat.srch_last) begin
          state_next = prq_pkg::S_IDLE;
        end else begin
          state_next = prq_pkg::S_SRCH_RD;
        end
      end
      prq_pkg::S_SHIFT_RD: state_next = prq_pkg::S_SHIFT_WR;
      prq_pkg::S_SHIFT_WR: begin
        if (stat.shift_last) state_next = prq_pkg::S_REM_DONE;
        else state_next = prq_pkg::S_SHIFT_RD;
      end
      prq_pkg::S_REM_DONE:  state_next = prq_pkg::S_IDLE;
      prq_pkg::S_PICK_RD:   state_next = prq_pkg::S_PICK_DONE;
      prq_pkg::S_PICK_DONE: state_next = prq_pkg::S_IDLE;
      default:              state_next = prq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = prq_pkg::CMD_NONE;
    case (state)
      prq_pkg::S_IDLE: begin
        if (start) cmd = prq_pkg::CMD_CAPTURE;
      end
      prq_pkg::S_DECODE: begin
        case (stat.func)
          prq_pkg::FUNC_ADD: cmd = prq_pkg::CMD_NONE;
          prq_pkg::FUNC_REMOVE: begin
            if (!stat.cur_valid || stat.count_zero) cmd = prq_pkg::CMD_FIN_NOT_FOUND;
          end
          prq_pkg::FUNC_PICK: begin
            if (!stat.mask_any) cmd = prq_pkg::CMD_FIN_OK;
          end
          default: cmd = prq_pkg::CMD_FIN_OK;
        endcase
      end
      prq_pkg::S_ADD:     cmd = prq_pkg::CMD_ADD;
      prq_pkg::S_SRCH_RD: cmd = prq_pkg::CMD_SRCH_RD;
      prq_pkg::S_SRCH_CMP: begin
        if (stat.match) begin
          // A match on the tail entry needs no compaction.
          if (stat.srch_last) cmd = prq_pkg::CMD_REMOVE_DONE;
        end else if (stat.srch_last) begin
          cmd = prq_pkg::CMD_FIN_NOT_FOUND;
        end else begin
          cmd = prq_pkg::CMD_SRCH_NEXT;
        end
      end
      prq_pkg::S_SHIFT_RD:  cmd = prq_pkg::CMD_SHIFT_RD;
      prq_pkg::S_SHIFT_WR:  cmd = prq_pkg::CMD_SHIFT_WR;
      prq_pkg::S_REM_DONE:  cmd = prq_pkg::CMD_REMOVE_DONE;
      prq_pkg::S_PICK_RD:   cmd = prq_pkg::CMD_PICK_RD;
      prq_pkg::S_PICK_DONE: cmd = prq_pkg::CMD_PICK_DONE;
      default:              cmd = prq_pkg::CMD_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/prq_datapath.sv
// ----------------------------------------------------------------------------
// prq_datapath
// Slot memory, per-level counts, ready mask and result registers.
// ----------------------------------------------------------------------------
module prq_datapath #(
  parameter int PRIORITY_LEVELS = 16,
  parameter int LEVEL_DEPTH     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prq_pkg::prq_cmd_t    cmd,
  output prq_pkg::prq_status_t stat,
  input  logic [1:0]           func,
  input  logic [3:0]           process_id,
  input  logic [3:0]           item_priority,
  input  logic                 current_valid,
  input  logic [3:0]           current_id,
  input  logic [3:0]           current_priority,
  output logic                 done,
  output logic                 picked_valid,
  output logic [3:0]           picked_id,
  output logic                 request_soft_int,
  output logic                 request_dispatch,
  output logic [1:0]           status,
  output logic [15:0]          ready_mask
);

  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int IW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS = PRIORITY_LEVELS * LEVEL_DEPTH;
  localparam int AW = $clog2(SLOTS);
  localparam int MW = (PRIORITY_LEVELS > 16) ? PRIORITY_LEVELS : 16;

  function automatic logic [LW-1:0] clamp_lvl(input logic [3:0] v);
    logic [5:0] w;
    w = {2'b00, v};
    if (w >= 6'(PRIORITY_LEVELS)) w = 6'(PRIORITY_LEVELS - 1);
    return w[LW-1:0];
  endfunction

  logic [1:0]    func_r;
  logic [3:0]    pid_r;
  logic [LW-1:0] item_lvl_r;
  logic          cur_valid_r;
  logic [3:0]    cur_id_r;
  logic [LW-1:0] cur_lvl_r;
  logic [IW-1:0] idx;

  logic [CW-1:0]              level_count [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] level_mask;

  logic [3:0] slots [SLOTS];
  logic [3:0] rdata;

  logic [LW-1:0] op_lvl;
  logic [LW-1:0] top_lvl;
  logic [CW-1:0] n;
  logic          full;
  logic [AW-1:0] base;
  logic [AW-1:0] top_base;
  logic [CW:0]   idx_ext;
  logic [CW:0]   n_ext;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [3:0]    wdata;
  logic [MW-1:0] mask_wide;

  assign op_lvl   = (func_r == prq_pkg::FUNC_REMOVE) ? cur_lvl_r : item_lvl_r;
  assign n        = level_count[op_lvl];
  assign full     = (n >= CW'(LEVEL_DEPTH));
  assign base     = AW'(op_lvl) * AW'(LEVEL_DEPTH);
  assign top_base = AW'(top_lvl) * AW'(LEVEL_DEPTH);
  assign idx_ext  = (CW + 1)'(idx);
  assign n_ext    = (CW + 1)'(n);

  // Highest set bit of the ready mask.
  always_comb begin
    top_lvl = '0;
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      if (level_mask[l]) top_lvl = LW'(l);
    end
  end

  assign stat.func       = func_r;
  assign stat.cur_valid  = cur_valid_r;
  assign stat.count_zero = (n == '0);
  assign stat.match      = (rdata == cur_id_r);
  assign stat.srch_last  = ((idx_ext + (CW + 1)'(1)) >= n_ext);
  assign stat.shift_last = ((idx_ext + (CW + 1)'(2)) >= n_ext);
  assign stat.mask_any   = |level_mask;

  always_comb begin
    we    = 1'b0;
    waddr = base + AW'(idx);
    wdata = rdata;
    re    = 1'b0;
    raddr = base + AW'(idx);
    case (cmd)
      prq_pkg::CMD_ADD: begin
        we    = !full;
        waddr = base + AW'(n);
        wdata = pid_r;
      end
      prq_pkg::CMD_SHIFT_WR: we = 1'b1;
      prq_pkg::CMD_SRCH_RD:  re = 1'b1;
      prq_pkg::CMD_SHIFT_RD: begin
        re    = 1'b1;
        raddr = base + AW'(idx) + AW'(1);
      end
      prq_pkg::CMD_PICK_RD: begin
        re    = 1'b1;
        raddr = top_base;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) slots[waddr] <= wdata;
    if (re) rdata <= slots[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd == prq_pkg::CMD_CAPTURE) begin
      func_r      <= func;
      pid_r       <= process_id;
      item_lvl_r  <= clamp_lvl(item_priority);
      cur_valid_r <= current_valid;
      cur_id_r    <= current_id;
      cur_lvl_r   <= clamp_lvl(current_priority);
    end
    if (cmd == prq_pkg::CMD_CAPTURE) begin
      idx <= '0;
    end else if (cmd == prq_pkg::CMD_SRCH_NEXT || cmd == prq_pkg::CMD_SHIFT_WR) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) level_count[l] <= '0;
      level_mask <= '0;
    end else begin
      if (cmd == prq_pkg::CMD_ADD && !full) begin
        level_count[op_lvl] <= n + CW'(1);
        level_mask[op_lvl]  <= 1'b1;
      end else if (cmd == prq_pkg::CMD_REMOVE_DONE) begin
        level_count[op_lvl] <= n - CW'(1);
        if (n == CW'(1)) level_mask[op_lvl] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd == prq_pkg::CMD_ADD) || (cmd == prq_pkg::CMD_FIN_OK) ||
              (cmd == prq_pkg::CMD_FIN_NOT_FOUND) || (cmd == prq_pkg::CMD_REMOVE_DONE) ||
              (cmd == prq_pkg::CMD_PICK_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      prq_pkg::CMD_ADD: begin
        picked_valid     <= 1'b0;
        picked_id        <= 4'd0;
        request_dispatch <= !full && !cur_valid_r;
        request_soft_int <= !full && cur_valid_r && (item_lvl_r > cur_lvl_r);
        status           <= full ? prq_pkg::ST_FULL : prq_pkg::ST_OK;
      end
      prq_pkg::CMD_FIN_OK, prq_pkg::CMD_REMOVE_DONE: begin
        picked_valid     <= 1'b0;
        picked_id        <= 4'd0;
        request_dispatch <= 1'b0;
        request_soft_int <= 1'b0;
        status           <= prq_pkg::ST_OK;
      end
      prq_pkg::CMD_FIN_NOT_FOUND: begin
        picked_valid     <= 1'b0;
        picked_id        <= 4'd0;
        request_dispatch <= 1'b0;
        request_soft_int <= 1'b0;
        status           <= prq_pkg::ST_NOT_FOUND;
      end
      prq_pkg::CMD_PICK_DONE: begin
        picked_valid     <= 1'b1;
        picked_id        <= rdata;
        request_dispatch <= 1'b0;
        request_soft_int <= 1'b0;
        status           <= prq_pkg::ST_OK;
      end
      default: begin
        picked_valid <= picked_valid;
      end
    endcase
  end

  assign mask_wide  = MW'(level_mask);
  assign ready_mask = mask_wide[15:0];

endmodule

FILE: hw/rtl/priority_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Per-level FIFOs of process identifiers with a ready mask of non-empty levels.
// ----------------------------------------------------------------------------
// An item is captured and decoded; an add then writes its slot, a pick reads
// the head of the top level; early rejects and the unused func code finish at
// decode. A remove walks its level through the slot memory, reading each entry
// searched and reading and writing each entry moved. One item at a time: busy
// stays high until the done cycle, when a new start may be taken. Synchronous
// reset empties every level at once; the receiver cannot stall results.
module priority_ready_queue_scheduler #(
  parameter int PRIORITY_LEVELS = 16,
  parameter int LEVEL_DEPTH     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [3:0]  process_id,
  input  logic [3:0]  item_priority,
  input  logic        current_valid,
  input  logic [3:0]  current_id,
  input  logic [3:0]  current_priority,
  output logic        done,
  output logic        picked_valid,
  output logic [3:0]  picked_id,
  output logic        request_soft_int,
  output logic        request_dispatch,
  output logic [1:0]  status,
  output logic [15:0] ready_mask
);

  prq_pkg::prq_cmd_t    cmd;
  prq_pkg::prq_status_t stat;

  prq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  prq_datapath #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .LEVEL_DEPTH     (LEVEL_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .func             (func),
    .process_id       (process_id),
    .item_priority    (item_priority),
    .current_valid    (current_valid),
    .current_id       (current_id),
    .current_priority (current_priority),
    .done             (done),
    .picked_valid     (picked_valid),
    .picked_id        (picked_id),
    .request_soft_int (request_soft_int),
    .request_dispatch (request_dispatch),
    .status           (status),
    .ready_mask       (ready_mask)
  );

endmodule

FILE: hw/rtl/prq_checker.sv
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module prq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        picked_valid,
  input logic [3:0]  picked_id,
  input logic        request_soft_int,
  input logic        request_dispatch,
  input logic [1:0]  status
);

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result is only shown once the block has finished its item.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // A result without a picked process carries a zero identifier.
  a_pick_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !picked_valid) |-> (picked_id == 4'd0))
    else $error("picked_id nonzero without a pick");

  // At most one request per add, and only on a successful add.
  a_requests: assert property (@(posedge clk) disable iff (rst)
    (done && (request_soft_int || request_dispatch)) |->
      (!(request_soft_int && request_dispatch) && status == prq_pkg::ST_OK &&
       !picked_valid))
    else $error("inconsistent request flags");

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Sends add, remove and pick commands to the priority ready queue scheduler.
// A private copy of the per-level queues predicts each answer, and every done
// strobe is checked field by field against the oldest predicted answer.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 16;
  localparam int DEPTH = 16;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int SETTLE_CYCLES = 4 * DEPTH + 16;
  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_TAIL = 150;

  typedef struct packed {
    logic        picked_valid;
    logic [3:0]  picked_id;
    logic        soft_int;
    logic        dispatch;
    logic [1:0]  status;
    logic [15:0] mask;
  } sched_answer_t;

  class ready_queue_scoreboard;
    logic [3:0]        slot [LEVELS][DEPTH];
    int unsigned       fill [LEVELS];
    logic [LEVELS-1:0] ready;
    sched_answer_t     answers_due [$];
    int unsigned       mismatches;

    function new();
      foreach (fill[l]) fill[l] = 0;
      ready = '0;
      mismatches = 0;
    endfunction

    function int unsigned level_of(logic [3:0] v);
      return (int'(v) >= LEVELS) ? LEVELS - 1 : int'(v);
    endfunction

    function int unsigned outstanding();
      return answers_due.size();
    endfunction

    // Chooses a queued process at random so that removes can hit real entries.
    function bit pick_resident(output logic [3:0] id, output logic [3:0] lvl);
      int unsigned held [$];
      int unsigned l;
      int unsigned idx;
      foreach (fill[k]) if (fill[k] > 0) held.push_back(k);
      if (held.size() == 0) return 0;
      l = held[$urandom_range(0, held.size() - 1)];
      idx = $urandom_range(0, fill[l] - 1);
      id = slot[l][idx];
      lvl = l[3:0];
      return 1;
    endfunction

    function sched_answer_t schedule_answer(logic [1:0] f, logic [3:0] pid,
                                            logic [3:0] prio, logic cur_valid,
                                            logic [3:0] cur_id,
                                            logic [3:0] cur_prio);
      sched_answer_t ans;
      int unsigned lvl;
      int unsigned cur_lvl;
      int unsigned i;
      int unsigned top;
      bit hit;
      ans = '0;
      ans.status = prq_pkg::ST_OK;
      lvl = level_of(prio);
      cur_lvl = level_of(cur_prio);
      case (f)
        prq_pkg::FUNC_ADD: begin
          if (fill[lvl] >= DEPTH) begin
            ans.status = prq_pkg::ST_FULL;
          end else begin
            slot[lvl][fill[lvl]] = pid;
            fill[lvl]++;
            ready[lvl] = 1'b1;
            if (!cur_valid) ans.dispatch = 1'b1;
            else if (lvl > cur_lvl) ans.soft_int = 1'b1;
          end
        end
        prq_pkg::FUNC_REMOVE: begin
          hit = 0;
          i = 0;
          if (cur_valid) begin
            while (!hit && i < fill[cur_lvl]) begin
              if (slot[cur_lvl][i] == cur_id) hit = 1;
              else i++;
            end
          end
          if (!hit) begin
            ans.status = prq_pkg::ST_NOT_FOUND;
          end else begin
            // Only the entry nearest the head goes; the rest close up behind it.
            for (int unsigned j = i; j + 1 < fill[cur_lvl]; j++)
              slot[cur_lvl][j] = slot[cur_lvl][j + 1];
            fill[cur_lvl]--;
            if (fill[cur_lvl] == 0) ready[cur_lvl] = 1'b0;
          end
        end
        prq_pkg::FUNC_PICK: begin
          if (ready != '0) begin
            top = 0;
            for (int unsigned l = 0; l < LEVELS; l++) if (ready[l]) top = l;
            ans.picked_valid = 1'b1;
            ans.picked_id = slot[top][0];
          end
        end
        default: ;
      endcase
      ans.mask = ready[15:0];
      return ans;
    endfunction

    function void note_item(logic [1:0] f, logic [3:0] pid, logic [3:0] prio,
                            logic cur_valid, logic [3:0] cur_id,
                            logic [3:0] cur_prio);
      answers_due.push_back(schedule_answer(f, pid, prio, cur_valid, cur_id, cur_prio));
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_answer(sched_answer_t got);
      sched_answer_t want;
      if (answers_due.size() == 0) begin
        report("done strobe with no item outstanding");
        return;
      end
      want = answers_due.pop_front();
      compare_field("picked_valid", 32'(got.picked_valid), 32'(want.picked_valid));
      compare_field("picked_id", 32'(got.picked_id), 32'(want.picked_id));
      compare_field("request_soft_int", 32'(got.soft_int), 32'(want.soft_int));
      compare_field("request_dispatch", 32'(got.dispatch), 32'(want.dispatch));
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("ready_mask", 32'(got.mask), 32'(want.mask));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  func = prq_pkg::FUNC_ADD;
  logic [3:0]  process_id = '0;
  logic [3:0]  item_priority = '0;
  logic        current_valid = 1'b0;
  logic [3:0]  current_id = '0;
  logic [3:0]  current_priority = '0;
  logic        busy;
  logic        done;
  logic        picked_valid;
  logic [3:0]  picked_id;
  logic        request_soft_int;
  logic        request_dispatch;
  logic [1:0]  status;
  logic [15:0] ready_mask;

  ready_queue_scoreboard sched_sb = new();

  priority_ready_queue_scheduler #(
    .PRIORITY_LEVELS(LEVELS),
    .LEVEL_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .process_id(process_id),
    .item_priority(item_priority),
    .current_valid(current_valid),
    .current_id(current_id),
    .current_priority(current_priority),
    .done(done),
    .picked_valid(picked_valid),
    .picked_id(picked_id),
    .request_soft_int(request_soft_int),
    .request_dispatch(request_dispatch),
    .status(status),
    .ready_mask(ready_mask)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      sched_sb.check_answer(sched_answer_t'({picked_valid, picked_id, request_soft_int,
                                             request_dispatch, status, ready_mask}));
    end
  end

  // Presents one item at the falling edge and holds it until it is taken.
  task automatic send_item(logic [1:0] f, logic [3:0] pid, logic [3:0] prio,
                           logic cur_valid, logic [3:0] cur_id, logic [3:0] cur_prio);
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    process_id <= pid;
    item_priority <= prio;
    current_valid <= cur_valid;
    current_id <= cur_id;
    current_priority <= cur_prio;
    do @(posedge clk); while (busy);
    sched_sb.note_item(f, pid, prio, cur_valid, cur_id, cur_prio);
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_all_answered();
    @(negedge clk);
    start <= 1'b0;
    while (sched_sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic fill_level(logic [3:0] lvl, int extra);
    for (int k = 0; k < DEPTH + extra; k++)
      send_item(prq_pkg::FUNC_ADD, 4'($urandom_range(0, 15)), lvl,
                1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)));
  endtask

  // A random mix of adds, removes, picks and no-ops; most removes name a process that is really queued.
  task automatic send_random_item(output bit counted);
    logic [1:0] f;
    logic [3:0] pid;
    logic [3:0] prio;
    logic       cur_valid;
    logic [3:0] cur_id;
    logic [3:0] cur_prio;
    int sel;
    pid = 4'($urandom_range(0, 15));
    prio = 4'($urandom_range(0, 15));
    cur_valid = 1'($urandom_range(0, 1));
    cur_id = 4'($urandom_range(0, 15));
    cur_prio = 4'($urandom_range(0, 15));
    sel = $urandom_range(0, 99);
    if (sel < 36) begin
      f = prq_pkg::FUNC_ADD;
    end else if (sel < 72) begin
      f = prq_pkg::FUNC_REMOVE;
      if ($urandom_range(0, 9) < 8 && sched_sb.pick_resident(cur_id, cur_prio))
        cur_valid = 1'b1;
    end else if (sel < 95) begin
      f = prq_pkg::FUNC_PICK;
    end else begin
      f = FUNC_NOP;
    end
    send_item(f, pid, prio, cur_valid, cur_id, cur_prio);
    counted = (f != FUNC_NOP);
  endtask

  initial begin
    int sent;
    bit counted;
    bit gaps_on;
    bit drained;
    sent = 0;
    gaps_on = 1;
    drained = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    send_item(prq_pkg::FUNC_PICK, 4'd0, 4'd0, 1'b0, 4'd0, 4'd0);
    send_item(prq_pkg::FUNC_REMOVE, 4'd3, 4'd2, 1'b0, 4'd3, 4'd2);
    send_item(prq_pkg::FUNC_REMOVE, 4'd3, 4'd2, 1'b1, 4'd3, 4'd2);
    send_item(FUNC_NOP, 4'hf, 4'hf, 1'b1, 4'hf, 4'hf);
    send_item(prq_pkg::FUNC_ADD, 4'd0, 4'd0, 1'b0, 4'd0, 4'd0);
    send_item(prq_pkg::FUNC_ADD, 4'hf, 4'hf, 1'b1, 4'hf, 4'd0);
    send_item(prq_pkg::FUNC_ADD, 4'd9, 4'd4, 1'b1, 4'd1, 4'd4);
    send_item(prq_pkg::FUNC_ADD, 4'd10, 4'd3, 1'b1, 4'd2, 4'hf);
    send_item(prq_pkg::FUNC_ADD, 4'd5, 4'd7, 1'b1, 4'd0, 4'd7);
    send_item(prq_pkg::FUNC_ADD, 4'd5, 4'd7, 1'b1, 4'd0, 4'd7);
    send_item(prq_pkg::FUNC_PICK, 4'd0, 4'd0, 1'b1, 4'd0, 4'd0);
    send_item(prq_pkg::FUNC_REMOVE, 4'd0, 4'd0, 1'b1, 4'd5, 4'd7);
    send_item(prq_pkg::FUNC_REMOVE, 4'd0, 4'd0, 1'b1, 4'hf, 4'hf);
    send_item(prq_pkg::FUNC_PICK, 4'hf, 4'hf, 1'b0, 4'hf, 4'hf);
    // Fill one level to the brim, then one more add must be refused.
    for (int k = 0; k <= DEPTH; k++)
      send_item(prq_pkg::FUNC_ADD, k[3:0], 4'd12, 1'b1, 4'd0, 4'd12);
    send_item(prq_pkg::FUNC_REMOVE, 4'd0, 4'd0, 1'b1, 4'd7, 4'd12);
    send_item(prq_pkg::FUNC_REMOVE, 4'd0, 4'd0, 1'b1, 4'hf, 4'd12);
    send_item(prq_pkg::FUNC_REMOVE, 4'd0, 4'd0, 1'b1, 4'd0, 4'd12);
    send_item(prq_pkg::FUNC_PICK, 4'd0, 4'd0, 1'b0, 4'd0, 4'd0);

    while (sent < RANDOM_ITEMS) begin
      if (sent % 64 == 0) gaps_on = $urandom_range(0, 2) != 0;
      if (gaps_on && sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 8));
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_all_answered();
        drained = 1;
      end
      if (sent % 350 == 175) begin
        fill_level(4'($urandom_range(0, 15)), 2);
        sent += DEPTH + 2;
      end
      send_random_item(counted);
      if (counted) sent++;
    end

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sched_sb.mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
